// ===== rtl/ffla_pkg.sv =====
// shared constants, codes and control types for the handle allocator
package ffla_pkg;

  localparam int POOL_SIZE   = 256;
  localparam int HANDLE_W    = 8;
  localparam int PTR_W       = $clog2(POOL_SIZE);
  localparam int CNT_W       = PTR_W + 1;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_TRY   = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NONE_FREED = 2'd1,
    ST_BAD_FREE   = 2'd2,
    ST_EXHAUSTED  = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic accept;  // latch request word and read queue head
    logic commit;  // apply state update and load result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy_free;  // latched request is a deallocate
  } dp_stat_t;

endpackage

// ===== rtl/ffla_ctrl.sv =====
// sequencer for the handle allocator: request handshake, commit timing, result valid
module ffla_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output ffla_pkg::dp_cmd_t dp_cmd,
  input  ffla_pkg::dp_stat_t dp_stat
);
  import ffla_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   free_cnt_r, free_cnt_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  assign dp_cmd.accept = in_tvalid && (state_r == S_IDLE);
  assign dp_cmd.commit = (state_r == S_EXEC) && slot_free;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    free_cnt_nxt  = free_cnt_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          // tracks whether the last committed word was a deallocate
          free_cnt_nxt  = dp_stat.busy_free;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      free_cnt_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      free_cnt_r  <= free_cnt_nxt;
    end
  end

endmodule

// ===== rtl/ffla_dp.sv =====
// datapath for the handle allocator: bitmap, freed-handle queue, counters, result register
module ffla_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ffla_pkg::dp_cmd_t                 dp_cmd,
  output ffla_pkg::dp_stat_t                dp_stat,
  input  logic [ffla_pkg::CMD_W-1:0]        in_command,
  input  logic [ffla_pkg::HANDLE_W-1:0]     in_handle,
  output logic [ffla_pkg::HANDLE_W-1:0]     out_handle,
  output logic [ffla_pkg::STATUS_W-1:0]     out_status
);
  import ffla_pkg::*;

  logic [POOL_SIZE-1:0] alloc_map_r;
  logic [HANDLE_W-1:0]  queue_mem [POOL_SIZE];
  logic [HANDLE_W-1:0]  head_data_r;

  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [PTR_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     qcount_r, qcount_nxt;
  logic [CNT_W-1:0]     fresh_r, fresh_nxt;

  logic [CMD_W-1:0]     cmd_r;
  logic [HANDLE_W-1:0]  hin_r;
  logic                 hin_held_r;
  logic [HANDLE_W-1:0]  hout_r, hout_nxt;
  status_t              status_r, status_nxt;

  logic                 map_we;
  logic [PTR_W-1:0]     map_addr;
  logic                 map_val;
  logic                 q_we;
  logic                 q_nonempty;
  logic                 fresh_left;

  assign q_nonempty = (qcount_r != '0);
  assign fresh_left = (fresh_r != CNT_W'(POOL_SIZE));
  assign dp_stat.busy_free = (cmd_r == CMD_FREE);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    qcount_nxt = qcount_r;
    fresh_nxt  = fresh_r;
    hout_nxt   = '0;
    status_nxt = ST_OK;
    map_we     = 1'b0;
    map_addr   = hin_r[PTR_W-1:0];
    map_val    = 1'b0;
    q_we       = 1'b0;
    case (cmd_r)
      CMD_ALLOC, CMD_TRY: begin
        if (q_nonempty) begin
          // reuse the oldest freed handle
          hout_nxt   = head_data_r;
          head_nxt   = head_r + 1'b1;
          qcount_nxt = qcount_r - 1'b1;
          map_we     = 1'b1;
          map_addr   = head_data_r[PTR_W-1:0];
          map_val    = 1'b1;
        end else if (cmd_r == CMD_TRY) begin
          status_nxt = ST_NONE_FREED;
        end else if (fresh_left) begin
          hout_nxt  = fresh_r[HANDLE_W-1:0];
          fresh_nxt = fresh_r + 1'b1;
          map_we    = 1'b1;
          map_addr  = fresh_r[PTR_W-1:0];
          map_val   = 1'b1;
        end else begin
          status_nxt = ST_EXHAUSTED;
        end
      end
      CMD_FREE: begin
        if (hin_held_r) begin
          map_we     = 1'b1;
          q_we       = 1'b1;
          tail_nxt   = tail_r + 1'b1;
          qcount_nxt = qcount_r + 1'b1;
        end else begin
          status_nxt = ST_BAD_FREE;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_map_r <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      qcount_r    <= '0;
      fresh_r     <= '0;
    end else if (dp_cmd.commit) begin
      if (map_we) begin
        alloc_map_r[map_addr] <= map_val;
      end
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      qcount_r <= qcount_nxt;
      fresh_r  <= fresh_nxt;
    end
  end

  // request word and result word, allocated bit of the handle read with the request
  always_ff @(posedge clk) begin
    if (dp_cmd.accept) begin
      cmd_r      <= in_command;
      hin_r      <= in_handle;
      hin_held_r <= alloc_map_r[in_handle[PTR_W-1:0]];
    end
    if (dp_cmd.commit) begin
      hout_r   <= hout_nxt;
      status_r <= status_nxt;
    end
  end

  // freed-handle queue memory, head read issued with the request
  always_ff @(posedge clk) begin
    if (dp_cmd.commit && q_we) begin
      queue_mem[tail_r] <= hin_r;
    end
    if (dp_cmd.accept) begin
      head_data_r <= queue_mem[head_r];
    end
  end

  assign out_handle = hout_r;
  assign out_status = status_r;

endmodule

// ===== rtl/fifo_free_list_handle_allocator.sv =====
// top level of the fifo free-list handle allocator
// Grants handles 0..255 from a fixed pool of 256. Allocate (command 0) reuses the oldest freed
// handle, otherwise the next never-used one, and reports pool exhausted when neither is left;
// try allocate (command 1) only reuses freed handles; deallocate (command 2) returns a held
// handle to the freed queue and rejects any other handle without changing state. Each request
// word first makes the registered reads of the freed-queue head and of the handle's allocated
// bit, then updates the bitmap, queue pointers and counters and loads the result register.
// A new request is taken while the previous result still waits on the output side; a stalled
// output holds the update step. All state is ready right after reset.
module fifo_free_list_handle_allocator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ffla_pkg::IN_DATA_W-1:0]       in_tdata,   // command[1:0], handle_in[9:2]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ffla_pkg::OUT_DATA_W-1:0]      out_tdata   // handle_out[7:0], status[9:8]
);
  import ffla_pkg::*;

  dp_cmd_t              dp_cmd;
  dp_stat_t             dp_stat;
  logic [HANDLE_W-1:0]  out_handle;
  logic [STATUS_W-1:0]  out_status;

  ffla_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat)
  );

  ffla_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat),
    .in_command (in_tdata[CMD_W-1:0]),
    .in_handle  (in_tdata[CMD_W+HANDLE_W-1:CMD_W]),
    .out_handle (out_handle),
    .out_status (out_status)
  );

  assign out_tdata = {{(OUT_DATA_W-HANDLE_W-STATUS_W){1'b0}}, out_status, out_handle};

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one still executing");

  // failures never grant a handle
  a_fail_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[HANDLE_W+STATUS_W-1:HANDLE_W] != ST_OK) |->
      (out_tdata[HANDLE_W-1:0] == '0))
    else $error("failed request carries a nonzero handle");

  // a new result only follows an executing request
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.commit |-> !in_tready && !(out_tvalid && !out_tready))
    else $error("result committed outside execute or into a full output register");

endmodule

// ===== verif/ffla_grant_checker.sv =====
// checker for the handle allocator: predicts each grant and compares the result words
`timescale 1ns / 1ps

module ffla_grant_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [ffla_pkg::IN_DATA_W-1:0]  in_tdata,   // command[1:0], handle_in[9:2]
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [ffla_pkg::OUT_DATA_W-1:0] out_tdata,  // handle_out[7:0], status[9:8]
  output int                              n_fail,
  output int                              n_pending
);
  import ffla_pkg::*;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    status_t             status;
  } grant_t;

  bit                  held_map [POOL_SIZE];
  logic [HANDLE_W-1:0] released_q [$];
  int unsigned         fresh_next;
  grant_t              pending_grants [$];

  // next state of the pool for one request word, and the grant it yields
  function automatic grant_t serve_request(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] hin);
    grant_t g;
    g.handle = '0;
    g.status = ST_OK;
    case (cmd)
      CMD_ALLOC, CMD_TRY: begin
        // oldest freed handle wins over a fresh one
        if (released_q.size() > 0) begin
          g.handle = released_q.pop_front();
          held_map[g.handle] = 1'b1;
        end else if (cmd == CMD_TRY) begin
          g.status = ST_NONE_FREED;
        end else if (fresh_next < POOL_SIZE) begin
          g.handle = fresh_next[HANDLE_W-1:0];
          held_map[fresh_next] = 1'b1;
          fresh_next++;
        end else begin
          g.status = ST_EXHAUSTED;
        end
      end
      CMD_FREE: begin
        if (held_map[hin]) begin
          held_map[hin] = 1'b0;
          released_q.push_back(hin);
        end else begin
          g.status = ST_BAD_FREE;
        end
      end
      default: ;  // unused code does nothing
    endcase
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    if (!rst_n) begin
      foreach (held_map[i]) held_map[i] = 1'b0;
      released_q.delete();
      pending_grants.delete();
      fresh_next = 0;
      n_fail     = 0;
    end else begin
      // check the outgoing word first so a same-edge request cannot pair with it
      if (out_tvalid && out_tready) begin
        got.handle = out_tdata[HANDLE_W-1:0];
        got.status = status_t'(out_tdata[HANDLE_W +: STATUS_W]);
        if (pending_grants.size() == 0) begin
          $display("%0t: unexpected word, expected none, got handle %0d status %s",
                   $time, got.handle, got.status.name());
          n_fail++;
        end else begin
          want = pending_grants.pop_front();
          if (got.handle !== want.handle) begin
            $display("%0t: handle mismatch, expected %0d, got %0d",
                     $time, want.handle, got.handle);
            n_fail++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %s, got %s",
                     $time, want.status.name(), got.status.name());
            n_fail++;
          end
        end
      end
      if (in_tvalid && in_tready)
        pending_grants.push_back(serve_request(in_tdata[CMD_W-1:0],
                                               in_tdata[CMD_W +: HANDLE_W]));
    end
    n_pending = pending_grants.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// testbench top for the handle allocator: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import ffla_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int PAD_W        = IN_DATA_W - CMD_W - HANDLE_W;
  localparam int RANDOM_WORDS = 800;
  localparam int STALL_LIMIT  = 2000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int fail_count;
  int pending_count;
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int idle_cycles  = 0;
  int allocs_sent  = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fifo_free_list_handle_allocator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ffla_grant_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .n_fail     (fail_count),
    .n_pending  (pending_count)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // ends the run when neither side moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("fifo_free_list_handle_allocator test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] h);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{PAD_W{1'b0}}, h, cmd};
    if (cmd == CMD_ALLOC) allocs_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  // hold off the sender until every grant has come back
  task automatic drain_grants();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    @(posedge clk);
  endtask

  // free a handle that is likely held, now and then any handle at all
  task automatic send_free();
    int hi;
    hi = (allocs_sent > POOL_SIZE) ? POOL_SIZE - 1 : ((allocs_sent > 0) ? allocs_sent - 1 : 0);
    if ($urandom_range(4) == 0)
      send_word(CMD_FREE, HANDLE_W'($urandom_range(POOL_SIZE - 1)));
    else
      send_word(CMD_FREE, HANDLE_W'($urandom_range(hi)));
  endtask

  task automatic send_random(bit filling);
    int r;
    r = $urandom_range(99);
    if (r < (filling ? 70 : 15))
      send_word(CMD_ALLOC, HANDLE_W'($urandom_range(POOL_SIZE - 1)));
    else if (r < (filling ? 80 : 30))
      send_word(CMD_TRY, HANDLE_W'($urandom_range(POOL_SIZE - 1)));
    else if (r < 95)
      send_free();
    else if ($urandom_range(1) == 0)
      send_word(CMD_NOP, HANDLE_W'($urandom_range(POOL_SIZE - 1)));
    else
      send_word(CMD_FREE, HANDLE_W'($urandom_range(POOL_SIZE - 1)));
  endtask

  initial begin
    bit filling;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pool, bad frees, fifo order, unused code
    send_word(CMD_TRY,   8'd0);    // nothing freed yet
    send_word(CMD_FREE,  8'd0);    // never granted
    send_word(CMD_FREE,  8'd255);
    send_word(CMD_NOP,   8'd255);
    send_word(CMD_ALLOC, 8'd255);  // fresh 0
    send_word(CMD_ALLOC, 8'd0);    // fresh 1
    send_word(CMD_ALLOC, 8'd0);    // fresh 2
    send_word(CMD_FREE,  8'd1);
    send_word(CMD_FREE,  8'd1);    // already freed
    send_word(CMD_TRY,   8'd255);  // reuses 1
    send_word(CMD_FREE,  8'd0);
    send_word(CMD_FREE,  8'd2);
    send_word(CMD_ALLOC, 8'd0);    // oldest freed is 0
    send_word(CMD_TRY,   8'd0);    // then 2
    send_word(CMD_TRY,   8'd0);    // queue empty again
    send_word(CMD_FREE,  8'hAA);
    send_word(CMD_FREE,  8'h55);
    send_word(CMD_NOP,   8'd0);
    send_word(CMD_ALLOC, 8'd0);    // fresh 3
    send_word(CMD_FREE,  8'd3);
    send_word(CMD_ALLOC, 8'd0);    // reuses 3
    drain_grants();

    // random: bursts that fill the pool toward exhaustion or drain it
    in_idle_pct  = 36;
    out_idle_pct = 61;
    filling = 1'b1;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 3) begin
        drain_grants();
        in_idle_pct  = 61;
        out_idle_pct = 36;
      end else if (i == 2 * RANDOM_WORDS / 3) begin
        drain_grants();
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if (i % 32 == 0) filling = ($urandom_range(2) != 2);
      send_random(filling);
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("fifo_free_list_handle_allocator test passed");
    end else begin
      $display("fifo_free_list_handle_allocator test failed");
    end
    $finish;
  end

endmodule
